// ----- hw/rtl/square_matrix_multiply_defines.svh -----
// Assertion macros used by the port-level checker
`ifndef SQUARE_MATRIX_MULTIPLY_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_DEFINES_SVH
// Assert that a condition implies a property in the same cycle
`define SMM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%s failed", "lbl");
// Assert that a condition implies a property in the next cycle
`define SMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%s failed", "lbl");
`endif

// ----- hw/rtl/smm_pkg.sv -----
// Shared types and constants for the matrix multiply engine
package smm_pkg;
  localparam int unsigned ElemW = 16;
  localparam int unsigned ProdW = 32;
  localparam int unsigned AccW  = 35;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned DimW  = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_START      = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Tag carried with each product term along the cell chain
  typedef struct packed {
    logic            vld;
    logic            first;
    logic            fin;
    logic            last;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } tag_t;
endpackage

// ----- hw/rtl/square_matrix_multiply.sv -----
// Top level of the matrix multiply engine
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | cmd, row, col, element
// out     | output    | out_valid/out_ready| out_row, out_col, product, last
// cfg     | input     | cfg_we             | cfg_wdata (dimension)
//
// During a start, the n terms of each product element issue through three
// chained cells (read, multiply, accumulate); the next element issues only
// once its sum has left the chain and the output register is empty. The
// input is held off for the whole run. A product waiting while out_ready
// is low stalls further issue.
// Reset clears control state; the matrix stores are undefined until loaded.
module square_matrix_multiply #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we,
  input  logic [smm_pkg::DimW-1:0]          cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smm_pkg::CmdW-1:0]          cmd_i,
  input  logic [smm_pkg::IdxW-1:0]          row_i,
  input  logic [smm_pkg::IdxW-1:0]          col_i,
  input  logic signed [smm_pkg::ElemW-1:0]  element_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [smm_pkg::IdxW-1:0]          out_row_o,
  output logic [smm_pkg::IdxW-1:0]          out_col_o,
  output logic signed [smm_pkg::AccW-1:0]   product_o,
  output logic                              last_o
);
  localparam int unsigned Cells = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned KW    = $clog2(MAX_DIM);
  localparam int unsigned NC    = 3;

  logic [smm_pkg::DimW-1:0] dim_q;
  logic [KW:0]              n;
  smm_pkg::state_e          st_q, st_d;
  logic [KW-1:0]            i_q, j_q, k_q;
  logic [smm_pkg::ElemW-1:0] left_mem [Cells];
  logic [smm_pkg::ElemW-1:0] right_mem [Cells];
  logic                     issue, seq_end, in_acc, pipe_busy, ld_ok;
  logic [AW-1:0]            wa;

  // Saturate the configured dimension to the range 1 to MAX_DIM
  always_comb begin
    if (dim_q == '0) begin
      n = (KW+1)'(1);
    end else if (32'(dim_q) > MAX_DIM) begin
      n = (KW+1)'(MAX_DIM);
    end else begin
      n = (KW+1)'(dim_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= smm_pkg::DimW'(MAX_DIM);
    end else if (cfg_we) begin
      dim_q <= cfg_wdata;
    end
  end

  // Output register, one entry, and the chain output feeds it
  smm_pkg::tag_t                    tag_c [NC+1];
  logic signed [smm_pkg::ElemW-1:0] a_c [NC+1];
  logic signed [smm_pkg::ElemW-1:0] b_c [NC+1];
  logic signed [smm_pkg::ProdW-1:0] p_c [NC+1];
  logic signed [smm_pkg::AccW-1:0]  acc_c [NC+1];
  logic                             ovld_q;
  logic                             olast_q;
  logic [smm_pkg::IdxW-1:0]         orow_q, ocol_q;
  logic signed [smm_pkg::AccW-1:0]  oprod_q;

  // Issue only when no finished product is in flight or waiting
  assign pipe_busy = tag_c[1].fin | tag_c[2].fin | tag_c[3].fin;
  assign issue     = (st_q == smm_pkg::ST_RUN) && !ovld_q && !pipe_busy;
  assign seq_end   = issue && ((KW+1)'(k_q) == n - 1'b1) && ((KW+1)'(j_q) == n - 1'b1)
                     && ((KW+1)'(i_q) == n - 1'b1);
  assign in_ready  = (st_q == smm_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      smm_pkg::ST_IDLE: begin
        if (in_acc && cmd_i == smm_pkg::CMD_START) st_d = smm_pkg::ST_RUN;
      end
      smm_pkg::ST_RUN: begin
        if (seq_end) st_d = smm_pkg::ST_DRAIN;
      end
      smm_pkg::ST_DRAIN: begin
        if (!pipe_busy && (!ovld_q || out_ready) && !tag_c[NC].fin)
          st_d = smm_pkg::ST_IDLE;
      end
      default: st_d = smm_pkg::ST_IDLE;
    endcase
  end

  // Advance the i, j, k sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= smm_pkg::ST_IDLE;
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
    end else begin
      st_q <= st_d;
      if (in_acc) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (issue) begin
        if ((KW+1)'(k_q) == n - 1'b1) begin
          k_q <= '0;
          if ((KW+1)'(j_q) == n - 1'b1) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  // Write loads into the stores, read operands for the first cell
  assign ld_ok = (32'(row_i) < 32'(n)) && (32'(col_i) < 32'(n));
  assign wa    = AW'(32'(row_i) * MAX_DIM + 32'(col_i));

  always_ff @(posedge clk_i) begin
    if (in_acc && ld_ok && cmd_i == smm_pkg::CMD_LOAD_LEFT) left_mem[wa] <= element_i;
    if (in_acc && ld_ok && cmd_i == smm_pkg::CMD_LOAD_RIGHT) right_mem[wa] <= element_i;
    a_c[1] <= left_mem[AW'(32'(i_q) * MAX_DIM + 32'(k_q))];
    b_c[1] <= right_mem[AW'(32'(k_q) * MAX_DIM + 32'(j_q))];
  end

  // Read cell: the memory read register forms its data path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_c[1] <= '0;
    end else begin
      tag_c[1].vld   <= issue;
      tag_c[1].first <= (k_q == '0);
      tag_c[1].fin   <= issue && ((KW+1)'(k_q) == n - 1'b1);
      tag_c[1].last  <= seq_end;
      tag_c[1].row   <= smm_pkg::IdxW'(i_q);
      tag_c[1].col   <= smm_pkg::IdxW'(j_q);
    end
  end
  assign p_c[1]   = '0;
  assign acc_c[1] = '0;
  assign tag_c[0] = '0;
  assign a_c[0]   = '0;
  assign b_c[0]   = '0;
  assign p_c[0]   = '0;
  assign acc_c[0] = '0;

  // Multiply and accumulate cells
  for (genvar s = 1; s < NC; s++) begin : g_cell
    smm_cell #(.Stage(s)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tag_i (tag_c[s]),
      .a_i   (a_c[s]),
      .b_i   (b_c[s]),
      .p_i   (p_c[s]),
      .acc_i (acc_c[NC]),
      .tag_o (tag_c[s+1]),
      .a_o   (a_c[s+1]),
      .b_o   (b_c[s+1]),
      .p_o   (p_c[s+1]),
      .acc_o (acc_c[s+1])
    );
  end

  // Hold the finished product until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (tag_c[NC].vld && tag_c[NC].fin) begin
      ovld_q <= 1'b1;
    end else if (out_ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_c[NC].vld && tag_c[NC].fin) begin
      orow_q  <= tag_c[NC].row;
      ocol_q  <= tag_c[NC].col;
      oprod_q <= acc_c[NC];
      olast_q <= tag_c[NC].last;
    end
  end

  assign out_valid = ovld_q;
  assign out_row_o = orow_q;
  assign out_col_o = ocol_q;
  assign product_o = oprod_q;
  assign last_o    = olast_q;
endmodule

// ----- hw/rtl/smm_cell.sv -----
// One stage of the multiply-accumulate chain
module smm_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smm_pkg::tag_t                     tag_i,
  input  logic signed [smm_pkg::ElemW-1:0]  a_i,
  input  logic signed [smm_pkg::ElemW-1:0]  b_i,
  input  logic signed [smm_pkg::ProdW-1:0]  p_i,
  input  logic signed [smm_pkg::AccW-1:0]   acc_i,
  output smm_pkg::tag_t                     tag_o,
  output logic signed [smm_pkg::ElemW-1:0]  a_o,
  output logic signed [smm_pkg::ElemW-1:0]  b_o,
  output logic signed [smm_pkg::ProdW-1:0]  p_o,
  output logic signed [smm_pkg::AccW-1:0]   acc_o
);
  smm_pkg::tag_t                    tag_q;
  logic signed [smm_pkg::ElemW-1:0] a_q, b_q;
  logic signed [smm_pkg::ProdW-1:0] p_q;
  logic signed [smm_pkg::AccW-1:0]  acc_q;

  // Advance the valid tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  // Stage 0 registers operands, stage 1 multiplies, stage 2 accumulates
  always_ff @(posedge clk_i) begin
    a_q <= a_i;
    b_q <= b_i;
    if (Stage == 1) begin
      p_q <= a_i * b_i;
    end else begin
      p_q <= p_i;
    end
    if (Stage == 2) begin
      acc_q <= (tag_i.first ? '0 : acc_i) + smm_pkg::AccW'(p_i);
    end else begin
      acc_q <= acc_i;
    end
  end

  assign tag_o = tag_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign p_o   = p_q;
  assign acc_o = acc_q;
endmodule

// ----- hw/rtl/smm_checker.sv -----
// Port-level checker for the matrix multiply engine, bound to the top level
`include "square_matrix_multiply_defines.svh"
module smm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last_o
);
  `SMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `SMM_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid, !in_ready)
  `SMM_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_valid && out_ready && last_o, !out_valid)
endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .last_o   (last_o)
);
